// ----- src/link_reconnect_supervisor_macros.svh -----
// Assertion macros for the link reconnect supervisor.
`ifndef LINK_RECONNECT_SUPERVISOR_MACROS_SVH
`define LINK_RECONNECT_SUPERVISOR_MACROS_SVH

`ifndef SYNTH
`define LRS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("link supervisor check failed");
`define LRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("link supervisor check failed");
`else
`define LRS_ASSERT_IMP(label, ante, cons)
`define LRS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/lrs_pkg.sv -----
// Shared types and constants of the link reconnect supervisor.
package lrs_pkg;

    localparam logic [31:0] RETRY_CEILING = 32'd300000;
    localparam logic [31:0] DEF_INITIAL   = 32'd1000;
    localparam logic [31:0] DEF_MAX       = 32'd30000;
    localparam logic [30:0] DEF_KEEPALIVE = 31'd30000;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 304;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_POLL  = 2'd1;
    localparam logic [1:0] ACT_SEND  = 2'd2;
    localparam logic [1:0] ACT_STOP  = 2'd3;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_WAIT = 2'd1;
    localparam logic [1:0] MODE_CONN = 2'd2;

    localparam logic [1:0] RECV_MSG  = 2'd0;
    localparam logic [1:0] RECV_NONE = 2'd1;

    localparam logic [2:0] RC_OK    = 3'd0;
    localparam logic [2:0] RC_PEND  = 3'd1;
    localparam logic [2:0] RC_WRONG = 3'd2;
    localparam logic [2:0] RC_PING  = 3'd3;
    localparam logic [2:0] RC_LINK  = 3'd4;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_CONN  = 2'd1;
    localparam logic [1:0] EV_DISC  = 2'd2;
    localparam logic [1:0] EV_RETRY = 2'd3;

    localparam logic [1:0] REG_INITIAL   = 2'd0;
    localparam logic [1:0] REG_MAX       = 2'd1;
    localparam logic [1:0] REG_KEEPALIVE = 2'd2;
    localparam logic [1:0] REG_JITTER    = 2'd3;

    typedef struct packed {
        logic [31:0] init_wait;
        logic [31:0] max_wait;
        logic [30:0] keepalive;
        logic        jitter_off;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage

// ----- src/link_reconnect_supervisor.sv -----
// Link reconnect supervisor: backoff with full jitter, keepalive and link counters.
// Takes one action item at a time (start, poll, send, stop) and returns one result
// per item. An item goes through the EVAL and SEND states before its result is
// registered; one whose link drops or whose attempt fails with jitter active also
// goes through the DIV state, where the 32 steps of the bit-serial remainder unit
// compute random_word mod (window+1). s_tready is low while an item is in work. A
// result waits in the output register while the next item is taken; that item then
// waits for the output register to free before it completes.
`include "link_reconnect_supervisor_macros.svh"
module link_reconnect_supervisor import lrs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // now_time[31:0], open_ok[32], ping_ok[33], receive_outcome[35:34], send_ok[36],
    // failure_code[44:37], random_word[76:45], random_valid[77], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // return_code[2:0], reported_error[10:3], event_time[42:11], next_wait[74:43],
    // window_now[106:75], attempt_count[138:107], down_time[170:139],
    // connect_count[202:171], disconnect_count[234:203], received_count[266:235],
    // sent_count[298:267], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // event_kind[1:0]
    output logic [1:0]             m_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_SEND = 2'd3;

    cfg_t      cfg;
    mod_stat_t mod_stat;
    logic [31:0] mod_rem;
    logic        mod_start;

    logic [1:0]  state_reg;

    logic [1:0]  act_reg, recv_reg;
    logic [31:0] now_reg, rnd_reg;
    logic        open_ok_reg, ping_ok_reg, send_ok_reg, rvalid_reg;
    logic [7:0]  code_reg;

    logic [1:0]  mode_reg, mode_next;
    logic [31:0] window_reg, window_next;
    logic [31:0] deadline_reg;
    logic [31:0] down_start_reg, down_start_next;
    logic [31:0] keepalive_reg, keepalive_next;
    logic [31:0] attempts_reg, attempts_next;
    logic [31:0] connects_reg, connects_next;
    logic [31:0] disconnects_reg, disconnects_next;
    logic [31:0] received_reg, received_next;
    logic [31:0] sent_reg, sent_next;

    logic [2:0]  rc_reg, rc_next;
    logic [7:0]  err_reg, err_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] etime_reg, etime_next;
    logic [31:0] down_reg, down_next;
    logic [31:0] wait_reg;
    logic        drop_reg, drop_next;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]             m_tuser_reg;

    logic [31:0] since_deadline, since_ka;
    logic [32:0] doubled;
    logic [31:0] win_grow;
    logic        ka_due, ping_fail, plain_wait;

    lrs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_eff   (cfg)
    );

    lrs_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (rnd_reg),
        .divisor   ({1'b0, window_reg} + 33'd1),
        .stat      (mod_stat),
        .remainder (mod_rem)
    );

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        since_deadline = now_reg - deadline_reg;
        since_ka       = now_reg - keepalive_reg;
        ka_due         = !since_ka[31] && (since_ka[30:0] >= cfg.keepalive);
        doubled        = {window_reg, 1'b0};
        win_grow       = (doubled[32] || doubled[31:0] > cfg.max_wait) ?
                         cfg.max_wait : doubled[31:0];
        plain_wait     = cfg.jitter_off || (window_reg == 32'd0) || !rvalid_reg;

        mode_next        = mode_reg;
        window_next      = window_reg;
        down_start_next  = down_start_reg;
        keepalive_next   = keepalive_reg;
        attempts_next    = attempts_reg;
        connects_next    = connects_reg;
        disconnects_next = disconnects_reg;
        received_next    = received_reg;
        sent_next        = sent_reg;
        rc_next          = RC_OK;
        err_next         = 8'd0;
        kind_next        = EV_NONE;
        etime_next       = 32'd0;
        down_next        = 32'd0;
        drop_next        = 1'b0;
        ping_fail        = 1'b0;

        case (act_reg)
            ACT_START: begin
                attempts_next    = 32'd0;
                connects_next    = 32'd0;
                disconnects_next = 32'd0;
                received_next    = 32'd0;
                sent_next        = 32'd0;
                keepalive_next   = 32'd0;
                window_next      = cfg.init_wait;
                down_start_next  = now_reg;
                mode_next        = MODE_WAIT;
            end
            ACT_STOP: begin
                if (mode_reg == MODE_CONN) begin
                    disconnects_next = disconnects_reg + 32'd1;
                end
                mode_next = MODE_IDLE;
            end
            ACT_SEND: begin
                if (mode_reg != MODE_CONN) begin
                    rc_next = RC_WRONG;
                end else if (!send_ok_reg) begin
                    drop_next  = 1'b1;
                    rc_next    = RC_LINK;
                    err_next   = code_reg;
                    etime_next = now_reg;
                end else begin
                    sent_next = sent_reg + 32'd1;
                end
            end
            ACT_POLL: begin
                if (mode_reg == MODE_WAIT) begin
                    rc_next = RC_PEND;
                    if (!since_deadline[31]) begin
                        etime_next = now_reg;
                        if (open_ok_reg) begin
                            mode_next       = MODE_CONN;
                            connects_next   = connects_reg + 32'd1;
                            keepalive_next  = now_reg;
                            attempts_next   = 32'd0;
                            window_next     = cfg.init_wait;
                            down_next       = now_reg - down_start_reg;
                            down_start_next = now_reg;
                            kind_next       = EV_CONN;
                        end else begin
                            drop_next = 1'b1;
                            err_next  = code_reg;
                        end
                    end
                end else if (mode_reg == MODE_CONN) begin
                    if (ka_due) begin
                        keepalive_next = now_reg;
                        if (!ping_ok_reg) begin
                            ping_fail  = 1'b1;
                            drop_next  = 1'b1;
                            rc_next    = RC_PING;
                            err_next   = code_reg;
                            etime_next = now_reg;
                        end
                    end
                    if (!ping_fail) begin
                        if (recv_reg == RECV_MSG) begin
                            received_next = received_reg + 32'd1;
                        end else if (recv_reg == RECV_NONE) begin
                            rc_next = RC_PEND;
                        end else begin
                            drop_next  = 1'b1;
                            rc_next    = RC_LINK;
                            err_next   = code_reg;
                            etime_next = now_reg;
                        end
                    end
                end else begin
                    rc_next = RC_WRONG;
                end
            end
            default: ;
        endcase

        if (drop_next) begin
            if (mode_reg == MODE_CONN) begin
                disconnects_next = disconnects_reg + 32'd1;
                down_start_next  = now_reg;
                kind_next        = EV_DISC;
            end else begin
                kind_next = EV_RETRY;
            end
            mode_next     = MODE_WAIT;
            attempts_next = attempts_reg + 32'd1;
            window_next   = win_grow;
        end
    end

    assign mod_start = (state_reg == ST_EVAL) && drop_next && !plain_wait;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg     <= s_tuser;
            now_reg     <= s_tdata[31:0];
            open_ok_reg <= s_tdata[32];
            ping_ok_reg <= s_tdata[33];
            recv_reg    <= s_tdata[35:34];
            send_ok_reg <= s_tdata[36];
            code_reg    <= s_tdata[44:37];
            rnd_reg     <= s_tdata[76:45];
            rvalid_reg  <= s_tdata[77];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            mode_reg        <= MODE_IDLE;
            window_reg      <= 32'd0;
            deadline_reg    <= 32'd0;
            down_start_reg  <= 32'd0;
            keepalive_reg   <= 32'd0;
            attempts_reg    <= 32'd0;
            connects_reg    <= 32'd0;
            disconnects_reg <= 32'd0;
            received_reg    <= 32'd0;
            sent_reg        <= 32'd0;
            drop_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_SEND) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    mode_reg        <= mode_next;
                    window_reg      <= window_next;
                    down_start_reg  <= down_start_next;
                    keepalive_reg   <= keepalive_next;
                    attempts_reg    <= attempts_next;
                    connects_reg    <= connects_next;
                    disconnects_reg <= disconnects_next;
                    received_reg    <= received_next;
                    sent_reg        <= sent_next;
                    drop_reg        <= drop_next;
                    if (act_reg == ACT_START) begin
                        deadline_reg <= now_reg;
                    end
                    state_reg <= mod_start ? ST_DIV : ST_SEND;
                end
                ST_DIV: begin
                    if (mod_stat.done) begin
                        state_reg <= ST_SEND;
                    end
                end
                ST_SEND: begin
                    if (!m_tvalid_reg || m_tready) begin
                        if (drop_reg) begin
                            deadline_reg <= now_reg + wait_reg;
                        end
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EVAL) begin
            rc_reg    <= rc_next;
            err_reg   <= err_next;
            kind_reg  <= kind_next;
            etime_reg <= etime_next;
            down_reg  <= down_next;
            wait_reg  <= drop_next ? window_reg : 32'd0;
        end else if (state_reg == ST_DIV && mod_stat.done) begin
            wait_reg <= mod_rem;
        end
        if (state_reg == ST_SEND && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {5'd0, sent_reg, received_reg, disconnects_reg, connects_reg,
                            down_reg, attempts_reg, window_reg, wait_reg, etime_reg,
                            err_reg, rc_reg};
            m_tuser_reg <= kind_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `LRS_ASSERT_IMP(a_window_capped, 1'b1, window_reg <= RETRY_CEILING)
    `LRS_ASSERT_IMP(a_div_in_div_state, mod_stat.busy, state_reg == ST_DIV)
    `LRS_ASSERT_NEXT(a_accept_to_eval, s_tvalid && s_tready, state_reg == ST_EVAL)
    `LRS_ASSERT_IMP(a_connect_pending, m_tvalid && m_tuser == EV_CONN, m_tdata[2:0] == RC_PEND)

endmodule

// ----- src/lrs_cfg.sv -----
// Configuration registers and effective backoff and keepalive settings.
module lrs_cfg import lrs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg_eff
);

    logic [31:0] init_reg;
    logic [31:0] max_reg;
    logic [30:0] ka_reg;
    logic        jitter_reg;

    logic [31:0] init_sel, init_eff, max_sel, max_clamp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg   <= DEF_INITIAL;
            max_reg    <= DEF_MAX;
            ka_reg     <= DEF_KEEPALIVE;
            jitter_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_INITIAL:   init_reg   <= cfg_data;
                REG_MAX:       max_reg    <= cfg_data;
                REG_KEEPALIVE: ka_reg     <= cfg_data[30:0];
                REG_JITTER:    jitter_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        init_sel  = (init_reg == 32'd0) ? DEF_INITIAL : init_reg;
        init_eff  = (init_sel > RETRY_CEILING) ? RETRY_CEILING : init_sel;
        max_sel   = (max_reg == 32'd0) ? DEF_MAX : max_reg;
        max_clamp = (max_sel > RETRY_CEILING) ? RETRY_CEILING : max_sel;
        cfg_eff.init_wait  = init_eff;
        cfg_eff.max_wait   = (max_clamp < init_eff) ? init_eff : max_clamp;
        cfg_eff.keepalive  = (ka_reg == 31'd0) ? DEF_KEEPALIVE : ka_reg;
        cfg_eff.jitter_off = jitter_reg;
    end

endmodule

// ----- src/lrs_mod.sv -----
// Bit-serial remainder unit for the jitter draw.
module lrs_mod import lrs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [32:0] divisor,
    output mod_stat_t   stat,
    output logic [31:0] remainder
);

    logic        busy_reg, done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [32:0] rem_reg, div_reg;

    logic [32:0] trial;
    logic [33:0] diff;
    logic [32:0] rem_next;

    always_comb begin
        trial    = {rem_reg[31:0], quo_reg[31]};
        diff     = {1'b0, trial} - {1'b0, div_reg};
        rem_next = diff[33] ? trial : diff[32:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= 33'd0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg[31:0];

endmodule
